### rtl/core/cfr_pkg.sv
package cfr_pkg;

    // Frame store depth, in bytes
    localparam int BUF_LENGTH = 64;
    localparam int ADDR_W     = $clog2(BUF_LENGTH);
    // Store write position; wide enough to hold BUF_LENGTH itself
    localparam int CNT_W      = $clog2(BUF_LENGTH + 1);
    // Longest length byte accepted before the body starts
    localparam int LEN_MAX    = BUF_LENGTH - 2;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 8;
    localparam int OUT_LEN_W  = 6;
    localparam int HDR_FIELDS = 6;
    // Frame position of the first header field and of the first payload byte
    localparam int FLD_BASE   = 2;
    localparam int PAY_BASE   = 8;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd250;

    typedef struct packed {
        logic start;       // header seen while hunting
        logic relen;       // repeated header in place of the length
        logic take_len;    // length byte
        logic take_body;   // body byte
        logic clear;       // drop or end frame, reset counters
        logic start_emit;  // checksum good, latch payload length
        logic rd;          // read the next payload byte
        logic put;         // load the output register
        logic next;        // advance the payload index
    } t_cmd;

    typedef struct packed {
        logic hdr_hit;
        logic len_bad;
        logic rem_zero;
        logic full_next;
        logic sum_ok;
        logic last;
        logic out_space;
    } t_sts;

endpackage

### rtl/core/cfr_ram.sv
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/cfr_ctrl.sv
module cfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  cfr_pkg::t_sts i_sts,
    output cfr_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_HUNT = 5'b00001,
        S_LEN  = 5'b00010,
        S_BODY = 5'b00100,
        S_RD   = 5'b01000,
        S_PUT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   acc;

    assign o_stall = !((r_state == S_HUNT) || (r_state == S_LEN) || (r_state == S_BODY));
    assign acc     = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT: begin
                if (acc && i_sts.hdr_hit) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_LEN;
                end
            end
            S_LEN: begin
                if (acc) begin
                    if (i_sts.hdr_hit) begin
                        o_cmd.relen = 1'b1;
                    end else if (i_sts.len_bad) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_HUNT;
                    end else begin
                        o_cmd.take_len = 1'b1;
                        n_state        = S_BODY;
                    end
                end
            end
            S_BODY: begin
                if (acc) begin
                    if (!i_sts.rem_zero) begin
                        o_cmd.take_body = 1'b1;
                        if (i_sts.full_next) begin
                            o_cmd.clear = 1'b1;
                            n_state     = S_HUNT;
                        end
                    end else if (i_sts.sum_ok) begin
                        o_cmd.start_emit = 1'b1;
                        o_cmd.clear      = 1'b1;
                        n_state          = S_RD;
                    end else begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_HUNT;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_PUT;
            end
            S_PUT: begin
                if (i_sts.out_space) begin
                    o_cmd.put = 1'b1;
                    if (i_sts.last) begin
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.next = 1'b1;
                        n_state    = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    a_rd_then_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_state == S_PUT))
        else $error("payload read not followed by output load");

    a_emit_needs_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start_emit |-> (i_sts.sum_ok && i_sts.rem_zero))
        else $error("payload emitted without a good checksum");

    a_put_needs_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.put |-> i_sts.out_space)
        else $error("output register overwritten while held");

    a_no_take_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |=> (o_cmd.take_body == 1'b0 && o_cmd.take_len == 1'b0))
        else $error("body byte taken during payload run");

endmodule

### rtl/core/cfr_dpath.sv
module cfr_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cfr_pkg::BYTE_W-1:0]        i_cfg_data,
    input  logic [cfr_pkg::BYTE_W-1:0]        i_rx_byte,
    input  cfr_pkg::t_cmd                     i_cmd,
    output cfr_pkg::t_sts                     o_sts,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [cfr_pkg::BYTE_W-1:0]        o_source_addr,
    output logic [cfr_pkg::BYTE_W-1:0]        o_dest_addr,
    output logic [cfr_pkg::BYTE_W-1:0]        o_sequence_res,
    output logic [cfr_pkg::BYTE_W-1:0]        o_reserved_byte,
    output logic [cfr_pkg::BYTE_W-1:0]        o_command_id,
    output logic [cfr_pkg::BYTE_W-1:0]        o_ack_byte,
    output logic [cfr_pkg::OUT_LEN_W-1:0]     o_payload_length,
    output logic [cfr_pkg::OUT_LEN_W-1:0]     o_payload_index,
    output logic [cfr_pkg::BYTE_W-1:0]        o_payload_byte,
    output logic                              o_last
);

    logic [cfr_pkg::BYTE_W-1:0] r_hdr;
    logic [cfr_pkg::BYTE_W-1:0] r_first;
    logic [cfr_pkg::BYTE_W-1:0] r_fld [cfr_pkg::HDR_FIELDS];
    logic [cfr_pkg::CNT_W-1:0]  r_wi;
    logic [cfr_pkg::BYTE_W-1:0] r_sum;
    logic [cfr_pkg::LEN_W-1:0]  r_rem;
    logic [cfr_pkg::LEN_W-1:0]  r_len;
    logic [cfr_pkg::LEN_W-1:0]  r_idx;
    logic                       r_out_valid;

    logic [cfr_pkg::BYTE_W-1:0]    r_o_fld [cfr_pkg::HDR_FIELDS];
    logic [cfr_pkg::OUT_LEN_W-1:0] r_o_len;
    logic [cfr_pkg::OUT_LEN_W-1:0] r_o_idx;
    logic [cfr_pkg::BYTE_W-1:0]    r_o_byte;
    logic                          r_o_last;

    logic [cfr_pkg::BYTE_W-1:0]   ram_rdata;
    logic [cfr_pkg::ADDR_W:0]     rd_sum;
    logic [cfr_pkg::ADDR_W-1:0]   rd_addr;

    assign rd_sum  = (cfr_pkg::ADDR_W + 1)'(r_idx) + (cfr_pkg::ADDR_W + 1)'(cfr_pkg::PAY_BASE);
    assign rd_addr = rd_sum[cfr_pkg::ADDR_W-1:0];

    cfr_ram #(
        .WIDTH (cfr_pkg::BYTE_W),
        .DEPTH (cfr_pkg::BUF_LENGTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take_body),
        .i_waddr (r_wi[cfr_pkg::ADDR_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (i_cmd.rd),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_sts.hdr_hit   = (i_rx_byte == r_hdr);
        o_sts.len_bad   = (i_rx_byte == '0) ||
                          ({1'b0, i_rx_byte} > 9'(cfr_pkg::LEN_MAX));
        o_sts.rem_zero  = (r_rem == '0);
        o_sts.full_next = (r_wi == cfr_pkg::CNT_W'(cfr_pkg::BUF_LENGTH - 1));
        o_sts.sum_ok    = (r_wi > cfr_pkg::CNT_W'(cfr_pkg::PAY_BASE - 1)) &&
                          (r_sum == i_rx_byte);
        o_sts.last      = (r_len == '0) || (r_idx == r_len - cfr_pkg::LEN_W'(1));
        o_sts.out_space = !r_out_valid || !i_out_stall;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr       <= cfr_pkg::HEADER_RESET;
            r_wi        <= '0;
            r_sum       <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_hdr <= i_cfg_data;
            end
            priority if (i_cmd.clear) begin
                r_wi  <= '0;
                r_sum <= '0;
                r_rem <= '0;
            end else if (i_cmd.start) begin
                r_wi  <= cfr_pkg::CNT_W'(1);
                r_sum <= i_rx_byte;
            end else if (i_cmd.relen) begin
                r_wi  <= cfr_pkg::CNT_W'(1);
                r_sum <= r_first;
            end else if (i_cmd.take_len) begin
                r_wi  <= cfr_pkg::CNT_W'(2);
                r_sum <= r_sum + i_rx_byte;
                r_rem <= i_rx_byte;
            end else if (i_cmd.take_body) begin
                r_wi  <= r_wi + cfr_pkg::CNT_W'(1);
                r_sum <= r_sum + i_rx_byte;
                r_rem <= r_rem - cfr_pkg::LEN_W'(1);
            end else begin
                // Hold between frame events
                r_wi  <= r_wi;
                r_sum <= r_sum;
                r_rem <= r_rem;
            end
            if (i_cmd.put) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_first <= i_rx_byte;
        end
        if (i_cmd.take_body) begin
            for (int k = 0; k < cfr_pkg::HDR_FIELDS; k++) begin
                if (r_wi == cfr_pkg::CNT_W'(k + cfr_pkg::FLD_BASE)) begin
                    r_fld[k] <= i_rx_byte;
                end
            end
        end
        if (i_cmd.start_emit) begin
            r_len <= cfr_pkg::LEN_W'(r_wi - cfr_pkg::CNT_W'(cfr_pkg::PAY_BASE));
            r_idx <= '0;
        end else if (i_cmd.next) begin
            r_idx <= r_idx + cfr_pkg::LEN_W'(1);
        end
        if (i_cmd.put) begin
            r_o_fld  <= r_fld;
            r_o_len  <= r_len[cfr_pkg::OUT_LEN_W-1:0];
            r_o_idx  <= r_idx[cfr_pkg::OUT_LEN_W-1:0];
            r_o_byte <= (r_len == '0) ? '0 : ram_rdata;
            r_o_last <= o_sts.last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_source_addr    = r_o_fld[0];
    assign o_dest_addr      = r_o_fld[1];
    assign o_sequence_res   = r_o_fld[2];
    assign o_reserved_byte  = r_o_fld[3];
    assign o_command_id     = r_o_fld[4];
    assign o_ack_byte       = r_o_fld[5];
    assign o_payload_length = r_o_len;
    assign o_payload_index  = r_o_idx;
    assign o_payload_byte   = r_o_byte;
    assign o_last           = r_o_last;

endmodule

### rtl/core/checksummed_frame_receiver.sv
// The first result of a frame follows its checksum byte through a store read, then an output load.
// One received byte per cycle while parsing; during the payload run each result takes
// a store read, then an output load that waits while the output stalls; input stalled for the run.
// The run length is the payload length (a single result for an empty payload).
// Reset (i_rst_n, synchronous, active low): hunt for header, header register back to 250;
// the frame store is not cleared, so there is no startup sweep.
module checksummed_frame_receiver (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write: header byte
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cfr_pkg::BYTE_W-1:0]        i_cfg_data,
    // Received bytes
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [cfr_pkg::BYTE_W-1:0]        i_rx_byte,
    // Decoded payload bytes
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [cfr_pkg::BYTE_W-1:0]        o_source_addr,
    output logic [cfr_pkg::BYTE_W-1:0]        o_dest_addr,
    output logic [cfr_pkg::BYTE_W-1:0]        o_sequence_res,
    output logic [cfr_pkg::BYTE_W-1:0]        o_reserved_byte,
    output logic [cfr_pkg::BYTE_W-1:0]        o_command_id,
    output logic [cfr_pkg::BYTE_W-1:0]        o_ack_byte,
    output logic [cfr_pkg::OUT_LEN_W-1:0]     o_payload_length,
    output logic [cfr_pkg::OUT_LEN_W-1:0]     o_payload_index,
    output logic [cfr_pkg::BYTE_W-1:0]        o_payload_byte,
    output logic                              o_last
);

    // The frame format is: header, length L, L body bytes, checksum.
    // The checksum covers header, length and body, modulo 256. Body bytes 0..5
    // are the fixed header fields (kept in registers); the rest is payload,
    // kept in the frame store and replayed one transaction per byte.

    cfr_pkg::t_cmd cmd;
    cfr_pkg::t_sts sts;

    // Always accepted; the user must write configuration only between frames (unenforced).
    assign o_cfg_ready = 1'b1;

    // Controller: parse phase and payload replay sequencing
    cfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath: header compare, running sum, frame store, output register.
    // The output register decouples the two sides, so the parser is back to
    // hunting while the last result of a frame still waits downstream.
    cfr_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_rx_byte        (i_rx_byte),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_stall      (i_stall),
        .o_out_valid      (o_valid),
        .o_source_addr    (o_source_addr),
        .o_dest_addr      (o_dest_addr),
        .o_sequence_res   (o_sequence_res),
        .o_reserved_byte  (o_reserved_byte),
        .o_command_id     (o_command_id),
        .o_ack_byte       (o_ack_byte),
        .o_payload_length (o_payload_length),
        .o_payload_index  (o_payload_index),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last)
    );

endmodule
